// ===== hw/rtl/cfs_pkg.sv =====
`timescale 1ns / 1ps
package cfs_pkg;

   localparam int HOLD_DEPTH_DEF = 32;
   localparam int FIELD_LIMIT    = 256;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [7:0] QUOTE_CH = 8'h22;
   localparam logic [7:0] COMMA_CH = 8'h2C;
   localparam logic [7:0] SPACE_CH = 8'h20;
   localparam logic [7:0] WS_LO_CH = 8'h09;
   localparam logic [7:0] WS_HI_CH = 8'h0D;

   localparam logic [8:0] MAX_FIELDS_RST = 9'd256;

   typedef enum logic [2:0] {
      PM_START,
      PM_LEAD,
      PM_UNQ,
      PM_QUOTED,
      PM_QSEEN,
      PM_DONE
   } parse_mode_type;

   typedef enum logic [2:0] {
      OP_BYTE,
      OP_SPACE,
      OP_CLOSE,
      OP_RECORD,
      OP_CLOSE_RECORD
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RELEASE,
      BK_TAIL
   } back_state_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic [8:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [8:0] field_index;
      logic       byte_valid;
      logic       field_end;
      logic       record_end;
      logic       trim_overflow;
      logic       last;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hw/rtl/cfs_front.sv =====
`timescale 1ns / 1ps
module cfs_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [8:0]                csr_wdata,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      req_tlast,
   input  cfs_pkg::queue_status_type q_status,
   output logic                      q_push,
   output cfs_pkg::cmd_type          q_cmd
);

   localparam logic [10:0] LIMIT_CMP = 11'(cfs_pkg::FIELD_LIMIT);

   logic [8:0]              max_fields_ff;
   cfs_pkg::parse_mode_type mode_ff, mode_in, mode_eff;
   logic [8:0]              fd_ff, fd_in;
   logic                    accept, at_limit, is_ws, is_comma, is_quote, cmd_valid;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && cmd_valid;

   assign is_ws    = (req_tdata == cfs_pkg::SPACE_CH) ||
                     ((req_tdata >= cfs_pkg::WS_LO_CH) && (req_tdata <= cfs_pkg::WS_HI_CH));
   assign is_comma = (req_tdata == cfs_pkg::COMMA_CH);
   assign is_quote = (req_tdata == cfs_pkg::QUOTE_CH);

   assign at_limit = (fd_ff >= max_fields_ff) || ({2'b00, fd_ff} >= LIMIT_CMP);
   assign mode_eff = ((mode_ff == cfs_pkg::PM_START) && at_limit) ? cfs_pkg::PM_DONE : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_fields_ff <= cfs_pkg::MAX_FIELDS_RST;
         mode_ff       <= cfs_pkg::PM_START;
         fd_ff         <= '0;
      end else begin
         if (csr_we) begin
            max_fields_ff <= csr_wdata;
         end
         if (accept) begin
            mode_ff <= mode_in;
            fd_ff   <= fd_in;
         end
      end
   end

   // next parse state
   always_comb begin
      mode_in = mode_eff;
      fd_in   = fd_ff;
      if (req_tlast) begin
         mode_in = cfs_pkg::PM_START;
         fd_in   = '0;
      end else begin
         case (mode_eff)
            cfs_pkg::PM_START, cfs_pkg::PM_LEAD: begin
               if (is_comma) begin
                  mode_in = cfs_pkg::PM_START;
                  fd_in   = fd_ff + 9'd1;
               end else if ((mode_eff == cfs_pkg::PM_START) && is_quote) begin
                  mode_in = cfs_pkg::PM_QUOTED;
               end else if (is_ws) begin
                  mode_in = cfs_pkg::PM_LEAD;
               end else begin
                  mode_in = cfs_pkg::PM_UNQ;
               end
            end
            cfs_pkg::PM_UNQ: begin
               if (is_comma) begin
                  mode_in = cfs_pkg::PM_START;
                  fd_in   = fd_ff + 9'd1;
               end
            end
            cfs_pkg::PM_QUOTED: begin
               if (is_quote) begin
                  mode_in = cfs_pkg::PM_QSEEN;
               end
            end
            cfs_pkg::PM_QSEEN: begin
               if (is_quote) begin
                  mode_in = cfs_pkg::PM_QUOTED;
               end else begin
                  fd_in   = fd_ff + 9'd1;
                  mode_in = is_comma ? cfs_pkg::PM_START : cfs_pkg::PM_DONE;
               end
            end
            default: begin
               mode_in = cfs_pkg::PM_DONE;
            end
         endcase
      end
   end

   // command to the back end
   always_comb begin
      cmd_valid  = 1'b0;
      q_cmd.op   = cfs_pkg::OP_BYTE;
      q_cmd.data = req_tdata;
      q_cmd.idx  = fd_ff;
      if (req_tlast) begin
         cmd_valid = 1'b1;
         q_cmd.op  = (mode_eff != cfs_pkg::PM_DONE) ? cfs_pkg::OP_CLOSE_RECORD
                                                    : cfs_pkg::OP_RECORD;
      end else begin
         case (mode_eff)
            cfs_pkg::PM_START, cfs_pkg::PM_LEAD: begin
               if (is_comma) begin
                  cmd_valid = 1'b1;
                  q_cmd.op  = cfs_pkg::OP_CLOSE;
               end else if (!((mode_eff == cfs_pkg::PM_START) && is_quote) && !is_ws) begin
                  cmd_valid = 1'b1;
               end
            end
            cfs_pkg::PM_UNQ: begin
               cmd_valid = 1'b1;
               if (is_comma) begin
                  q_cmd.op = cfs_pkg::OP_CLOSE;
               end else if (is_ws) begin
                  q_cmd.op = cfs_pkg::OP_SPACE;
               end
            end
            cfs_pkg::PM_QUOTED: begin
               cmd_valid = !is_quote;
            end
            cfs_pkg::PM_QSEEN: begin
               cmd_valid = 1'b1;
               if (is_quote) begin
                  q_cmd.data = cfs_pkg::QUOTE_CH;
               end else begin
                  q_cmd.op = cfs_pkg::OP_CLOSE;
               end
            end
            default: begin
               cmd_valid = 1'b0;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/cfs_queue.sv =====
`timescale 1ns / 1ps
module cfs_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  cfs_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output cfs_pkg::cmd_type          head,
   output cfs_pkg::queue_status_type status
);

   localparam int PW = $clog2(cfs_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(cfs_pkg::QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(cfs_pkg::QUEUE_DEPTH);

   cfs_pkg::cmd_type entry_ff [cfs_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(cfs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(cfs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/cfs_back.sv =====
`timescale 1ns / 1ps
module cfs_back #(
   parameter int HOLD_DEPTH = cfs_pkg::HOLD_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cfs_pkg::cmd_type          head,
   input  cfs_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cfs_pkg::result_type       rsp_result
);

   localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
   localparam int CW = $clog2(HOLD_DEPTH + 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(HOLD_DEPTH);

   cfs_pkg::back_state_type state_ff, state_in;
   cfs_pkg::cmd_type        cur_ff, cur_in;
   cfs_pkg::result_type     res_ff, res;
   logic [7:0]              held_ff [HOLD_DEPTH];
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [IW-1:0]           rel_ff, rel_in, wr_idx;
   logic [7:0]              wr_byte;
   logic                    wr_en, emit, out_free, head_valid, rel_last, valid_ff;

   assign out_free   = !valid_ff || rsp_ready;
   assign head_valid = !q_status.empty;
   assign rel_last   = ({{(CW-IW){1'b0}}, rel_ff} + CW'(1)) == cnt_ff;
   assign rsp_valid  = valid_ff;
   assign rsp_result = res_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cfs_pkg::BK_IDLE: begin
            if (head_valid) begin
               if ((head.op == cfs_pkg::OP_BYTE) && (cnt_ff != '0)) begin
                  state_in = cfs_pkg::BK_RELEASE;
               end else if ((head.op == cfs_pkg::OP_SPACE) && (cnt_ff == FULL_CNT)) begin
                  state_in = cfs_pkg::BK_RELEASE;
               end else if ((head.op == cfs_pkg::OP_CLOSE_RECORD) && out_free) begin
                  state_in = cfs_pkg::BK_TAIL;
               end
            end
         end
         cfs_pkg::BK_RELEASE: begin
            if (out_free && rel_last) begin
               state_in = (cur_ff.op == cfs_pkg::OP_SPACE) ? cfs_pkg::BK_IDLE
                                                          : cfs_pkg::BK_TAIL;
            end
         end
         cfs_pkg::BK_TAIL: begin
            if (out_free) begin
               state_in = cfs_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = cfs_pkg::BK_IDLE;
         end
      endcase
   end

   // outputs and data path
   always_comb begin
      pop     = 1'b0;
      emit    = 1'b0;
      res     = '0;
      cnt_in  = cnt_ff;
      rel_in  = rel_ff;
      cur_in  = cur_ff;
      wr_en   = 1'b0;
      wr_idx  = '0;
      wr_byte = head.data;
      case (state_ff)
         cfs_pkg::BK_IDLE: begin
            if (head_valid) begin
               case (head.op)
                  cfs_pkg::OP_BYTE: begin
                     if (cnt_ff != '0) begin
                        pop    = 1'b1;
                        cur_in = head;
                        rel_in = '0;
                     end else if (out_free) begin
                        pop             = 1'b1;
                        emit            = 1'b1;
                        res.out_byte    = head.data;
                        res.field_index = head.idx;
                        res.byte_valid  = 1'b1;
                        res.last        = 1'b1;
                     end
                  end
                  cfs_pkg::OP_SPACE: begin
                     pop = 1'b1;
                     if (cnt_ff == FULL_CNT) begin
                        cur_in = head;
                        rel_in = '0;
                     end else begin
                        wr_en  = 1'b1;
                        wr_idx = cnt_ff[IW-1:0];
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
                  cfs_pkg::OP_CLOSE: begin
                     if (out_free) begin
                        pop             = 1'b1;
                        emit            = 1'b1;
                        res.field_index = head.idx;
                        res.field_end   = 1'b1;
                        res.last        = 1'b1;
                        cnt_in          = '0;
                     end
                  end
                  cfs_pkg::OP_RECORD: begin
                     if (out_free) begin
                        pop             = 1'b1;
                        emit            = 1'b1;
                        res.field_index = head.idx;
                        res.record_end  = 1'b1;
                        res.last        = 1'b1;
                        cnt_in          = '0;
                     end
                  end
                  cfs_pkg::OP_CLOSE_RECORD: begin
                     if (out_free) begin
                        pop             = 1'b1;
                        emit            = 1'b1;
                        cur_in          = head;
                        res.field_index = head.idx;
                        res.field_end   = 1'b1;
                        cnt_in          = '0;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         cfs_pkg::BK_RELEASE: begin
            if (out_free) begin
               emit              = 1'b1;
               res.out_byte      = held_ff[rel_ff];
               res.field_index   = cur_ff.idx;
               res.byte_valid    = 1'b1;
               res.trim_overflow = (cur_ff.op == cfs_pkg::OP_SPACE);
               res.last          = rel_last && (cur_ff.op == cfs_pkg::OP_SPACE);
               rel_in            = rel_ff + IW'(1);
               if (rel_last) begin
                  if (cur_ff.op == cfs_pkg::OP_SPACE) begin
                     wr_en   = 1'b1;
                     wr_byte = cur_ff.data;
                     cnt_in  = CW'(1);
                  end else begin
                     cnt_in = '0;
                  end
               end
            end
         end
         cfs_pkg::BK_TAIL: begin
            if (out_free) begin
               emit     = 1'b1;
               res.last = 1'b1;
               if (cur_ff.op == cfs_pkg::OP_CLOSE_RECORD) begin
                  res.field_index = cur_ff.idx + 9'd1;
                  res.record_end  = 1'b1;
               end else begin
                  res.out_byte    = cur_ff.data;
                  res.field_index = cur_ff.idx;
                  res.byte_valid  = 1'b1;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfs_pkg::BK_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rel_ff <= rel_in;
      if (emit) begin
         res_ff <= res;
      end
      if (wr_en) begin
         held_ff[wr_idx] <= wr_byte;
      end
   end

endmodule

// ===== hw/rtl/csv_field_splitter_top.sv =====
`timescale 1ns / 1ps
// An item's first result passes the queue entry and the result register when the back end is
// idle, and follows BK_RELEASE when held whitespace goes out first. One item per cycle while
// rsp_tready is high and each item gives at most one result; held bytes go out in BK_RELEASE,
// then BK_TAIL bar an overflowing whitespace byte; a line end closing an open field uses BK_TAIL.
// A four-entry command queue lets the front run ahead. Reset: clears parse state, field count,
// held count, queue and output valid; max_fields returns to 256. The hold store keeps no reset.
module csv_field_splitter_top #(
   parameter int HOLD_DEPTH = cfs_pkg::HOLD_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [8:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // line_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [16:8] field_index, [23:17] zero
   output logic [3:0]  rsp_tuser,   // [0] byte_valid, [1] field_end, [2] record_end,
                                    // [3] trim_overflow
   output logic        rsp_tlast    // last
);

   cfs_pkg::cmd_type          push_cmd, head;
   cfs_pkg::queue_status_type q_status;
   cfs_pkg::result_type       result;
   logic                      push, pop;

   cfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .q_push     (push),
      .q_cmd      (push_cmd)
   );

   cfs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   cfs_back #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {7'b0, result.field_index, result.out_byte};
   assign rsp_tuser = {result.trim_overflow, result.record_end, result.field_end,
                       result.byte_valid};
   assign rsp_tlast = result.last;

endmodule
